// ----- rtl/core/g7dec_pkg.sv -----
// Shared types, constants and character tables for the GSM 7-bit septet unpacking decoder.
package g7dec_pkg;

  // Septet codes and table bases.
  localparam logic [6:0] ESC_SEPTET = 7'h1b;
  localparam logic [7:0] EXT_BASE   = 8'h7f;
  localparam logic [6:0] CR_CODE    = 7'h0d;
  localparam logic [7:0] NO_MAP     = 8'hff;
  localparam int         ROM_SIZE   = 255;

  // Results one octet can cause: two characters and one end word, or
  // one character, a released held character and one end word.
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Reciprocal of seven scaled by 2^15; exact for dividends below 4096.
  localparam logic [12:0] DIV7_MUL   = 13'd4682;
  localparam int          DIV7_SHIFT = 15;

  localparam int          CFG_IDX_W     = 1;
  localparam int          CFG_DATA_W    = 9;
  localparam logic [8:0]  CAPACITY_RST  = 9'd256;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 1'b0,
    REG_USSD     = 1'b1
  } cfg_reg_t;

  typedef logic [7:0] rom_t [ROM_SIZE];
  typedef logic [7:0] plain_map_t [128];

  // One result word on the output channel.
  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       msg_end;
    logic [7:0] char_count;
  } res_t;

  // All result words that one accepted octet causes, in order.
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] r;
    logic [CNT_W-1:0]       n;
  } job_t;

  // Character ROM: default alphabet in the low half, extension table from EXT_BASE.
  localparam rom_t GSM_ROM = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0a, 8'hff, 8'hff,
    8'h0d, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff,
    8'hff, 8'hff, 8'h20, 8'h21, 8'h22, 8'h23, 8'h02, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a,
    8'h2b, 8'h2c,
    8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3a, 8'h3b,
    8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
    8'h49, 8'h4a,
    8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
    8'h58, 8'h59,
    8'h5a, 8'h3c, 8'h2f, 8'h3e, 8'h14, 8'h11, 8'hff, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h67, 8'h68,
    8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75,
    8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'h28, 8'h40, 8'h29, 8'h3d, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff,
    8'hff, 8'hff, 8'h0c, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h5e,
    8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h40, 8'hff,
    8'h01, 8'hff,
    8'h03, 8'hff, 8'h7b, 8'h7d, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h5c, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h5b, 8'h7e, 8'h5d, 8'hff, 8'h7c, 8'hff,
    8'hff, 8'hff,
    8'hff, 8'h5b, 8'h0e, 8'h1c, 8'h09, 8'hff, 8'h1f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'h5d,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h5c, 8'hff, 8'h0b, 8'hff, 8'hff, 8'hff, 8'h5e, 8'hff, 8'hff,
    8'h1e, 8'h7f,
    8'hff, 8'hff, 8'hff, 8'h7b, 8'h0f, 8'h1d, 8'hff, 8'h04, 8'h05, 8'hff, 8'hff, 8'h07, 8'hff,
    8'hff, 8'hff,
    8'hff, 8'h7d, 8'h08, 8'hff, 8'hff, 8'hff, 8'h7c, 8'hff, 8'h0c, 8'h06, 8'hff, 8'hff, 8'h7e,
    8'hff, 8'hff
  };

  // Reverse table for plain septets: the first ROM index holding the septet value.
  // Scanning from the top down lets the lowest index win.
  function automatic plain_map_t build_plain_map();
    plain_map_t m;
    for (int s = 0; s < 128; s++) begin
      m[s] = NO_MAP;
    end
    for (int i = ROM_SIZE - 1; i >= 0; i--) begin
      if (GSM_ROM[i] < 8'h80) begin
        m[GSM_ROM[i][6:0]] = 8'(i);
      end
    end
    return m;
  endfunction

  localparam plain_map_t PLAIN_MAP = build_plain_map();

  // Header septets to skip: ceil((udhl + 1) * 8 / 7), by multiplying with the reciprocal.
  function automatic logic [8:0] skip_len(input logic [7:0] udhl);
    logic [11:0] x;
    logic [24:0] p;
    x = {1'b0, udhl, 3'b000} + 12'd14;
    p = 25'(x) * 25'(DIV7_MUL);
    return p[DIV7_SHIFT+8:DIV7_SHIFT];
  endfunction

endpackage

// ----- rtl/core/g7dec_front.sv -----
// Front end: accepts packed octets, unpacks septets, maps characters and builds result jobs.
module g7dec_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [g7dec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [g7dec_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  input  logic                               q_full,
  input  logic [7:0]                         octet,
  input  logic                               msg_first,
  input  logic                               msg_last,
  input  logic [7:0]                         septet_count,
  input  logic                               udh_present,
  output logic                               push,
  output g7dec_pkg::job_t                    push_job
);
  import g7dec_pkg::*;

  // Configuration registers.
  logic [8:0]  output_capacity;
  logic        ussd_mode;

  // Message state.
  logic [13:0] bit_buffer, bit_buffer_next;
  logic [3:0]  bit_fill, bit_fill_next;
  logic [7:0]  skip_left, skip_left_next;
  logic [7:0]  septets_left, septets_left_next;
  logic        escape_pending, escape_pending_next;
  logic [7:0]  chars_emitted, chars_emitted_next;
  logic [7:0]  held_char, held_char_next;
  logic        held_valid, held_valid_next;

  logic        accept;
  logic [8:0]  limit;

  assign accept = in_valid && !q_full;
  assign limit  = (output_capacity == 9'd0) ? 9'd0 : output_capacity - 9'd1;

  // Decode one octet: up to two septets, then the end-of-message handling.
  always_comb begin
    logic [13:0]      bb;
    logic [3:0]       fill;
    logic [7:0]       skip;
    logic [7:0]       sl;
    logic             esc;
    logic [7:0]       ce;
    logic [7:0]       hc;
    logic             hv;
    logic [6:0]       s;
    logic [7:0]       c;
    logic             got;
    logic [8:0]       sk;
    logic [7:0]       delivered;
    logic [CNT_W-1:0] k;
    job_t             job;

    bb   = bit_buffer;
    fill = bit_fill;
    skip = skip_left;
    sl   = septets_left;
    esc  = escape_pending;
    ce   = chars_emitted;
    hc   = held_char;
    hv   = held_valid;
    s    = '0;
    c    = '0;
    got  = 1'b0;
    sk   = '0;
    delivered = '0;
    k    = '0;
    job  = '0;

    if (accept) begin
      // Message start clears state and sets up the header skip.
      if (msg_first) begin
        bb   = '0;
        fill = '0;
        skip = '0;
        esc  = 1'b0;
        ce   = '0;
        hc   = '0;
        hv   = 1'b0;
        sl   = septet_count;
        if (udh_present) begin
          sk = skip_len(octet);
          if (sk > {1'b0, septet_count}) begin
            sl = '0;
          end else begin
            skip = sk[7:0];
          end
        end
        if (sl != 8'd0 && limit == 9'd0) begin
          sl = '0;
        end
      end

      if (sl != 8'd0) begin
        bb   = bb | (14'(octet) << fill);
        fill = fill + 4'd8;
        for (int j = 0; j < 2; j++) begin
          if (fill >= 4'd7 && sl != 8'd0) begin
            s    = bb[6:0];
            bb   = bb >> 7;
            fill = fill - 4'd7;
            sl   = sl - 8'd1;
            got  = 1'b0;
            if (skip != 8'd0) begin
              skip = skip - 8'd1;
              if ({1'b0, ce} >= limit) begin
                sl = '0;
              end
            end else if (esc) begin
              esc = 1'b0;
              c   = GSM_ROM[EXT_BASE + 8'(s)];
              got = 1'b1;
            end else if (s == ESC_SEPTET && sl != 8'd0) begin
              esc = 1'b1;
            end else begin
              c   = PLAIN_MAP[s];
              got = 1'b1;
            end
            if (got) begin
              ce = ce + 8'd1;
              if ({1'b0, ce} >= limit) begin
                sl = '0;
              end
              // The closing character waits for the final octet in USSD mode.
              if (ussd_mode && sl == 8'd0) begin
                hc = c;
                hv = 1'b1;
              end else begin
                job.r[k] = '{char_code: c, char_valid: 1'b1, msg_end: 1'b0, char_count: 8'd0};
                k = k + 1'b1;
              end
            end
          end
        end
      end

      // Final octet: release or drop the held character, then the end word.
      if (msg_last) begin
        delivered = ce;
        if (hv) begin
          if (ussd_mode && octet[7:1] == CR_CODE) begin
            delivered = ce - 8'd1;
          end else begin
            job.r[k] = '{char_code: hc, char_valid: 1'b1, msg_end: 1'b0, char_count: 8'd0};
            k = k + 1'b1;
          end
        end
        job.r[k] = '{char_code: 8'd0, char_valid: 1'b0, msg_end: 1'b1, char_count: delivered};
        k = k + 1'b1;
        bb   = '0;
        fill = '0;
        skip = '0;
        sl   = '0;
        esc  = 1'b0;
        ce   = '0;
        hc   = '0;
        hv   = 1'b0;
      end
    end

    job.n = k;

    bit_buffer_next     = bb;
    bit_fill_next       = fill;
    skip_left_next      = skip;
    septets_left_next   = sl;
    escape_pending_next = esc;
    chars_emitted_next  = ce;
    held_char_next      = hc;
    held_valid_next     = hv;
    push_job            = job;
    push                = accept && (k != '0);
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAPACITY_RST;
      ussd_mode       <= 1'b0;
      bit_buffer      <= '0;
      bit_fill        <= '0;
      skip_left       <= '0;
      septets_left    <= '0;
      escape_pending  <= 1'b0;
      chars_emitted   <= '0;
      held_char       <= '0;
      held_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_CAPACITY: output_capacity <= cfg_data;
          REG_USSD:     ussd_mode       <= cfg_data[0];
          default:      ;
        endcase
      end
      bit_buffer     <= bit_buffer_next;
      bit_fill       <= bit_fill_next;
      skip_left      <= skip_left_next;
      septets_left   <= septets_left_next;
      escape_pending <= escape_pending_next;
      chars_emitted  <= chars_emitted_next;
      held_char      <= held_char_next;
      held_valid     <= held_valid_next;
    end
  end

  // A held character only exists once decoding of the message has ended.
  a_held_done: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> septets_left == 8'd0)
    else $error("held character while septets remain");

  // The final octet leaves no message state behind.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && msg_last |=> chars_emitted == 8'd0 && !held_valid && septets_left == 8'd0)
    else $error("message state not cleared after final octet");

endmodule

// ----- rtl/core/g7dec_queue.sv -----
// Two-entry job queue between the decoding front end and the output back end.
module g7dec_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  g7dec_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output g7dec_pkg::job_t head_job
);
  import g7dec_pkg::*;

  job_t       entries [2];
  logic       wr_ptr, wr_ptr_next;
  logic       rd_ptr, rd_ptr_next;
  logic [1:0] count, count_next;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_next = push ? ~wr_ptr : wr_ptr;
    rd_ptr_next = pop ? ~rd_ptr : rd_ptr;
    count_next  = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/g7dec_back.sv -----
// Back end: walks the head job one result word a cycle into the output register unless stalled.
module g7dec_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  g7dec_pkg::job_t head_job,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output g7dec_pkg::res_t out_res
);
  import g7dec_pkg::*;

  logic [CNT_W-1:0] idx, idx_next;
  logic             out_valid_next;
  logic             load;
  logic             job_done;

  // The output register takes a new word when it is empty or being taken.
  assign load     = head_valid && (!out_valid || !out_stall);
  assign job_done = (idx + 1'b1) == head_job.n;
  assign pop      = load && job_done;

  always_comb begin
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    if (load) begin
      out_valid_next = 1'b1;
      idx_next       = job_done ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= head_job.r[idx];
    end
  end

endmodule

// ----- rtl/core/gsm7_septet_unpack_decoder_top.sv -----
// Top level of the GSM 7-bit septet unpacking decoder.
// Packed SMS user-data octets go in, one word per octet, and decoded characters come out,
// one word per character, followed by one end word per message that carries the character
// count. The front end decodes an accepted octet in the cycle it is taken and puts all of
// its result words (up to three) as one job into a two-entry queue; while out_stall is low,
// the back end sends one word per cycle through an output register. The first word of an
// octet passes through the queue entry and the output register before it is presented.
// An octet yields result words as follows: none for an octet that only feeds header or
// escape septets or arrives with no septets left, one for a single character or a bare end
// word, two for a septet pair or a character with its end word, and three when a final
// octet also releases a held character or completes a pair. The input takes one octet per
// cycle while the queue has room; in_stall rises only while both queue entries hold jobs
// whose words are not yet all sent. The configuration port is always ready; registers
// should be written only while no message is in flight.
module gsm7_septet_unpack_decoder_top (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [g7dec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [g7dec_pkg::CFG_DATA_W-1:0] cfg_data,
  // Octet input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       octet,
  input  logic                             msg_first,
  input  logic                             msg_last,
  input  logic [7:0]                       septet_count,
  input  logic                             udh_present,
  // Character output channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       char_code,
  output logic                             char_valid,
  output logic                             msg_end,
  output logic [7:0]                       char_count
);
  import g7dec_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;
  res_t out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Decoding front end.
  g7dec_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .q_full       (q_full),
    .octet        (octet),
    .msg_first    (msg_first),
    .msg_last     (msg_last),
    .septet_count (septet_count),
    .udh_present  (udh_present),
    .push         (push),
    .push_job     (push_job)
  );

  // Job queue.
  g7dec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Output back end.
  g7dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign char_code  = out_res.char_code;
  assign char_valid = out_res.char_valid;
  assign msg_end    = out_res.msg_end;
  assign char_count = out_res.char_count;

endmodule
